@@ hdl/rlas_pkg.sv @@
`default_nettype none

package rlas_pkg;

    // field widths
    localparam int unsigned TICK_W  = 20;
    localparam int unsigned RETRY_W = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
    localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SSID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_DLY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONN_TO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RTRY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL_DLY = 3'd4;

    // reset values of the registers
    localparam logic [TICK_W-1:0]  RST_ACT_DLY  = 20'd3000;
    localparam logic [TICK_W-1:0]  RST_CONN_TO  = 20'd15000;
    localparam logic [RETRY_W-1:0] RST_MAX_RTRY = 8'd3;
    localparam logic [TICK_W-1:0]  RST_COOL_DLY = 20'd10000;

    // request codes
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_ACT  = 2'd1;
    localparam logic [1:0] REQ_OFF  = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_COND = 3'd1,
        MODE_ACT  = 3'd2,
        MODE_CONN = 3'd3,
        MODE_COOL = 3'd4
    } t_mode;

    typedef struct packed {
        logic               ssid_configured;
        logic [TICK_W-1:0]  activation_delay;
        logic [TICK_W-1:0]  connect_timeout;
        logic [RETRY_W-1:0] max_retries;
        logic [TICK_W-1:0]  cooldown_delay;
    } t_cfg;

    typedef struct packed {
        t_mode              mode;
        logic [TICK_W-1:0]  elapsed;
        logic [RETRY_W-1:0] retry;
        logic               ext_req;
    } t_state;

    typedef struct packed {
        logic [1:0] req_type;
        logic       mesh_ok;
        logic       neighbor_present;
        logic       peer_seen;
        logic       link_up;
    } t_item;

    typedef struct packed {
        t_mode mode;
        logic  radio_on;
        logic  start_radio;
        logic  stop_radio;
        logic  announce_up;
        logic  announce_down;
        logic  fault;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/rlas_in_if.sv @@
`default_nettype none

interface rlas_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic       mesh_ok;
    logic       neighbor_present;
    logic       peer_seen;
    logic       link_up;

    modport source (
        output valid, req_type, mesh_ok, neighbor_present, peer_seen, link_up,
        input  ready
    );
    modport sink (
        input  valid, req_type, mesh_ok, neighbor_present, peer_seen, link_up,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/rlas_out_if.sv @@
`default_nettype none

interface rlas_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic       radio_on;
    logic       start_radio;
    logic       stop_radio;
    logic       announce_up;
    logic       announce_down;
    logic       fault;

    modport source (
        output valid, mode, radio_on, start_radio, stop_radio, announce_up,
               announce_down, fault,
        input  ready
    );
    modport sink (
        input  valid, mode, radio_on, start_radio, stop_radio, announce_up,
               announce_down, fault,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/rlas_step.sv @@
`default_nettype none

// One state transition: current state, registers and one item in,
// next state and the result beat out.
module rlas_step
    import rlas_pkg::*;
(
    input  var t_cfg    i_cfg,
    input  var t_state  i_st,
    input  var t_item   i_item,
    output t_state      o_st,
    output t_result     o_res
);

    logic [TICK_W-1:0]  elapsed_inc;
    logic [RETRY_W-1:0] retry_inc;
    logic               cond;
    logic               start, stop, ann_up, ann_down, flt;

    // saturating increments
    assign elapsed_inc = (i_st.elapsed != TICK_MAX) ? i_st.elapsed + 1'b1 : i_st.elapsed;
    assign retry_inc   = (i_st.retry != RETRY_MAX) ? i_st.retry + 1'b1 : i_st.retry;

    // link condition
    assign cond = i_cfg.ssid_configured &&
                  ((i_item.mesh_ok && i_item.neighbor_present && i_item.peer_seen) ||
                   i_st.ext_req);

    always_comb begin
        o_st     = i_st;
        start    = 1'b0;
        stop     = 1'b0;
        ann_up   = 1'b0;
        ann_down = 1'b0;
        flt      = 1'b0;
        case (i_item.req_type)
            REQ_TICK: begin
                o_st.elapsed = elapsed_inc;
                case (i_st.mode)
                    MODE_IDLE: begin
                        if (cond) begin
                            o_st.mode    = MODE_COND;
                            o_st.elapsed = '0;
                        end
                    end
                    MODE_COND: begin
                        if (!cond) begin
                            o_st.mode    = MODE_IDLE;
                            o_st.elapsed = '0;
                            o_st.ext_req = 1'b0;
                        end else if (elapsed_inc >= i_cfg.activation_delay) begin
                            o_st.mode    = MODE_ACT;
                            o_st.elapsed = '0;
                            start        = 1'b1;
                        end
                    end
                    MODE_ACT: begin
                        if (i_item.link_up) begin
                            o_st.retry   = '0;
                            o_st.mode    = MODE_CONN;
                            o_st.elapsed = '0;
                            ann_up       = 1'b1;
                        end else if (elapsed_inc >= i_cfg.connect_timeout) begin
                            // connect attempt timed out: retry or give up
                            o_st.retry   = retry_inc;
                            o_st.elapsed = '0;
                            stop         = 1'b1;
                            if (retry_inc >= i_cfg.max_retries) begin
                                flt       = 1'b1;
                                o_st.mode = MODE_COOL;
                            end else begin
                                start = 1'b1;
                            end
                        end
                    end
                    MODE_CONN: begin
                        if (!cond || elapsed_inc >= i_cfg.connect_timeout) begin
                            stop         = 1'b1;
                            ann_down     = 1'b1;
                            o_st.ext_req = 1'b0;
                            o_st.mode    = MODE_COOL;
                            o_st.elapsed = '0;
                        end
                    end
                    MODE_COOL: begin
                        if (elapsed_inc >= i_cfg.cooldown_delay) begin
                            o_st.mode    = MODE_IDLE;
                            o_st.elapsed = '0;
                        end
                    end
                    default: begin
                        o_st.mode    = MODE_IDLE;
                        o_st.elapsed = '0;
                    end
                endcase
            end
            REQ_ACT: begin
                if (i_st.mode inside {MODE_IDLE, MODE_COND}) begin
                    o_st.ext_req = 1'b1;
                    if (i_st.mode == MODE_IDLE) begin
                        o_st.mode    = MODE_COND;
                        o_st.elapsed = '0;
                    end
                end
            end
            REQ_OFF: begin
                stop         = 1'b1;
                o_st.ext_req = 1'b0;
                o_st.retry   = '0;
                o_st.mode    = MODE_IDLE;
                o_st.elapsed = '0;
            end
            default: begin
                // unused code: no change, no strobes
            end
        endcase
    end

    // result beat; start is blocked without a network name
    always_comb begin
        o_res.mode          = o_st.mode;
        o_res.radio_on      = (o_st.mode == MODE_ACT) || (o_st.mode == MODE_CONN);
        o_res.start_radio   = start && i_cfg.ssid_configured;
        o_res.stop_radio    = stop;
        o_res.announce_up   = ann_up;
        o_res.announce_down = ann_down;
        o_res.fault         = flt;
    end

endmodule

`default_nettype wire

@@ hdl/radio_link_activation_sequencer.sv @@
`default_nettype none

// Channel   Dir  Beat contents
// i_in      in   req_type, mesh_ok, neighbor_present, peer_seen, link_up
// o_out     out  mode, radio_on, start_radio, stop_radio, announce_up,
//                announce_down, fault
// i_cfg_*   in   write enable, register index, write data (no read-back)
//
// Each input beat yields one output beat: it is held in the input register, then
// passes through the transition logic into the output register. A new beat is
// accepted every cycle while the output drains.
// The state advances when a beat moves from the input to the output register,
// so a stall at the output holds both stages and the input stops after one.
// Synchronous active-low reset restores register defaults and idle mode.
module radio_link_activation_sequencer
    import rlas_pkg::*;
(
    input  var logic                  i_clk,
    input  var logic                  i_rst_n,
    rlas_in_if.sink                   i_in,
    rlas_out_if.source                o_out,
    input  var logic                  i_cfg_we,
    input  var logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  var logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_st;
    t_state  n_st;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ssid_configured  <= 1'b0;
            r_cfg.activation_delay <= RST_ACT_DLY;
            r_cfg.connect_timeout  <= RST_CONN_TO;
            r_cfg.max_retries      <= RST_MAX_RTRY;
            r_cfg.cooldown_delay   <= RST_COOL_DLY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SSID:     r_cfg.ssid_configured  <= i_cfg_data[0];
                CFG_ACT_DLY:  r_cfg.activation_delay <= i_cfg_data[TICK_W-1:0];
                CFG_CONN_TO:  r_cfg.connect_timeout  <= i_cfg_data[TICK_W-1:0];
                CFG_MAX_RTRY: r_cfg.max_retries      <= i_cfg_data[RETRY_W-1:0];
                CFG_COOL_DLY: r_cfg.cooldown_delay   <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline control
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_item.req_type         <= i_in.req_type;
            r_item.mesh_ok          <= i_in.mesh_ok;
            r_item.neighbor_present <= i_in.neighbor_present;
            r_item.peer_seen        <= i_in.peer_seen;
            r_item.link_up          <= i_in.link_up;
        end
    end

    rlas_step u_step (
        .i_cfg  (r_cfg),
        .i_st   (r_st),
        .i_item (r_item),
        .o_st   (n_st),
        .o_res  (n_res)
    );

    // sequencer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode    <= MODE_IDLE;
            r_st.elapsed <= '0;
            r_st.retry   <= '0;
            r_st.ext_req <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (adv) begin
                r_st <= n_st;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.mode          = r_res.mode;
    assign o_out.radio_on      = r_res.radio_on;
    assign o_out.start_radio   = r_res.start_radio;
    assign o_out.stop_radio    = r_res.stop_radio;
    assign o_out.announce_up   = r_res.announce_up;
    assign o_out.announce_down = r_res.announce_down;
    assign o_out.fault         = r_res.fault;

    // result beat mode tracks the sequencer state
    a_mode_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (r_res.mode == r_st.mode))
        else $error("result mode differs from state mode");

    // a fault always comes with a radio stop
    a_fault_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.fault) |-> (r_res.stop_radio && r_res.mode == MODE_COOL))
        else $error("fault without stop or cool-down");

    // link-up announce only on entry to connected, with retries cleared
    a_up_conn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_res.announce_up) |=> (r_st.mode == MODE_CONN && r_st.retry == '0))
        else $error("announce up outside connected entry");

    // radio level follows the mode
    a_radio_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            (r_res.radio_on == (r_res.mode == MODE_ACT || r_res.mode == MODE_CONN)))
        else $error("radio_on inconsistent with mode");

endmodule

`default_nettype wire
